// ===== hdl/sm4_block_cipher_ecb_cbc_core_macros.svh =====
// Assertion macros for the SM4 core top level
`ifndef SM4_BLOCK_CIPHER_ECB_CBC_CORE_MACROS_SVH
`define SM4_BLOCK_CIPHER_ECB_CBC_CORE_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define SM4_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define SM4_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sm4_pkg.sv =====
// Package: SM4 widths, S-box, system parameters and round functions
package sm4_pkg;

    localparam int ROUNDS = 32;
    localparam int RND_W  = $clog2(ROUNDS);
    localparam int HALF_W = 64;
    localparam int WORD_W = 32;

    typedef enum logic [2:0] {
        REG_KEY_HIGH  = 3'd0,
        REG_KEY_LOW   = 3'd1,
        REG_IV_HIGH   = 3'd2,
        REG_IV_LOW    = 3'd3,
        REG_CHAINING  = 3'd4,
        REG_DIRECTION = 3'd5
    } t_reg_idx;

    localparam int REG_COUNT = 6;

    localparam logic [0:255][7:0] SBOX = {
        128'hd690e9fecce13db716b614c228fb2c05,
        128'h2b679a762abe04c3aa44132649860699,
        128'h9c4250f491ef987a33540b43edcfac62,
        128'he4b31ca9c908e89580df94fa758f3fa6,
        128'h4707a7fcf37317ba83593c19e6854fa8,
        128'h686b81b27164da8bf8eb0f4b70569d35,
        128'h1e240e5e6358d1a225227c3b01217887,
        128'hd40046579fd327524c3602e7a0c4c89e,
        128'heabf8ad240c738b5a3f7f2cef96115a1,
        128'he0ae5da49b341a55ad933230f58cb1e3,
        128'h1df6e22e8266ca60c02923ab0d534e6f,
        128'hd5db3745defd8e2f03ff6a726d6c5b51,
        128'h8d1baf92bbddbc7f11d95c411f105ad8,
        128'h0ac13188a5cd7bbd2d74d012b8e5b4b0,
        128'h8969974a0c96777e65b9f109c56ec684,
        128'h18f07dec3adc4d2079ee5f3ed7cb3948
    };

    localparam logic [0:3][WORD_W-1:0] FK = {
        32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc
    };

    function automatic logic [WORD_W-1:0] ck_word(input logic [RND_W-1:0] idx);
        logic [WORD_W-1:0] w;
        logic [7:0]        base;
        base = {1'b0, idx, 2'b00};
        for (int j = 0; j < 4; j++) begin
            w[WORD_W-1-8*j -: 8] = 8'((base + 8'(j)) * 8'd7);
        end
        return w;
    endfunction

    function automatic logic [WORD_W-1:0] sub_word(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] r;
        for (int k = 0; k < 4; k++) begin
            r[8*k +: 8] = SBOX[x[8*k +: 8]];
        end
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] lin_data(input logic [WORD_W-1:0] b);
        return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
                 ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
    endfunction

    function automatic logic [WORD_W-1:0] lin_key(input logic [WORD_W-1:0] b);
        return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
    endfunction

endpackage

// ===== hdl/sm4_if.sv =====
// Interfaces: SM4 block input channel and result output channel
interface sm4_in_if import sm4_pkg::*;;
    logic              valid;
    logic              ready;
    logic [HALF_W-1:0] block_high;
    logic [HALF_W-1:0] block_low;
    logic              first_block;

    modport source (output valid, block_high, block_low, first_block, input ready);
    modport sink   (input valid, block_high, block_low, first_block, output ready);
endinterface

interface sm4_out_if import sm4_pkg::*;;
    logic              valid;
    logic              ready;
    logic [HALF_W-1:0] result_high;
    logic [HALF_W-1:0] result_low;

    modport source (output valid, result_high, result_low, input ready);
    modport sink   (input valid, result_high, result_low, output ready);
endinterface

// ===== hdl/sm4_block_cipher_ecb_cbc_core.sv =====
// Top level: SM4 block cipher core, ECB or CBC, with APB register port
//
//   channel  | dir | handshake      | beat contents
//   ---------+-----+----------------+---------------------------------------
//   i_blk    | in  | valid / ready  | block_high, block_low, first_block
//   o_res    | out | valid / ready  | result_high, result_low
//   apb      | in  | psel / penable | 64-bit registers at byte address 8*i
//
// A block goes from accept to the result register through a read-ahead step of the
// round-key RAM, 32 rounds through the shared S-box/linear unit and a load step.
// The first block after a key write runs key expansion on the same unit first.
// Reset is synchronous: it clears registers, chain, key-ready flag and
// sequencer. The next beat is accepted while a result waits in the output register;
// the load step holds until that register is free.
`include "sm4_block_cipher_ecb_cbc_core_macros.svh"

module sm4_block_cipher_ecb_cbc_core import sm4_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sm4_in_if.sink            i_blk,
    sm4_out_if.source         o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [5:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_KEYX  = 5'b00010,
        S_PREP  = 5'b00100,
        S_ROUND = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    logic [HALF_W-1:0]       r_key_high, r_key_low, r_iv_high, r_iv_low;
    logic                    r_chaining, r_direction;
    t_state                  r_state, n_state;
    logic [RND_W-1:0]        r_cnt;
    logic                    r_keys_ready;
    logic                    r_ov;
    logic [2*HALF_W-1:0]     r_chain;
    logic [2*HALF_W-1:0]     r_blk;
    logic                    r_first;
    logic [0:3][WORD_W-1:0]  r_w;
    logic [2*HALF_W-1:0]     r_out;

    logic                    cfg_wr;
    t_reg_idx                cfg_idx;
    logic                    blk_acc;
    logic                    out_free;
    logic [WORD_W-1:0]       rk;
    logic [RND_W-1:0]        rd_base, rd_addr;
    logic [WORD_W-1:0]       mix_in, sb, mix_out, n_word;
    logic [2*HALF_W-1:0]     chain_cur, blk_start, res;

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite;
    assign cfg_idx  = t_reg_idx'(paddr[5:3]);
    assign blk_acc  = i_blk.valid & i_blk.ready;
    assign out_free = ~r_ov | o_res.ready;

    assign i_blk.ready       = (r_state == S_IDLE);
    assign o_res.valid       = r_ov;
    assign o_res.result_high = r_out[2*HALF_W-1:HALF_W];
    assign o_res.result_low  = r_out[HALF_W-1:0];

    always_comb begin
        unique case (cfg_idx)
            REG_KEY_HIGH:  prdata = r_key_high;
            REG_KEY_LOW:   prdata = r_key_low;
            REG_IV_HIGH:   prdata = r_iv_high;
            REG_IV_LOW:    prdata = r_iv_low;
            REG_CHAINING:  prdata = {63'd0, r_chaining};
            REG_DIRECTION: prdata = {63'd0, r_direction};
            default:       prdata = '0;
        endcase
    end

    // shared round unit: key schedule or data round
    assign mix_in  = r_w[1] ^ r_w[2] ^ r_w[3] ^ ((r_state == S_KEYX) ? ck_word(r_cnt) : rk);
    assign sb      = sub_word(mix_in);
    assign mix_out = (r_state == S_KEYX) ? lin_key(sb) : lin_data(sb);
    assign n_word  = r_w[0] ^ mix_out;

    // read ahead the round key of the next round
    assign rd_base = (r_state == S_PREP) ? '0 : RND_W'(r_cnt + 1'b1);
    assign rd_addr = r_direction ? ~rd_base : rd_base;

    sm4_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROUNDS)
    ) u_rk_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_KEYX),
        .i_waddr (r_cnt),
        .i_wdata (n_word),
        .i_raddr (rd_addr),
        .o_rdata (rk)
    );

    assign chain_cur = r_first ? {r_iv_high, r_iv_low} : r_chain;
    assign blk_start = (r_chaining & ~r_direction) ? (r_blk ^ chain_cur) : r_blk;
    assign res       = {r_w[3], r_w[2], r_w[1], r_w[0]}
                     ^ ((r_chaining & r_direction) ? r_chain : '0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (blk_acc) begin
                    n_state = r_keys_ready ? S_PREP : S_KEYX;
                end
            end
            S_KEYX: begin
                if (r_cnt == RND_W'(ROUNDS - 1)) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_state = S_ROUND;
            end
            S_ROUND: begin
                if (r_cnt == RND_W'(ROUNDS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high   <= '0;
            r_key_low    <= '0;
            r_iv_high    <= '0;
            r_iv_low     <= '0;
            r_chaining   <= 1'b0;
            r_direction  <= 1'b0;
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_keys_ready <= 1'b0;
            r_ov         <= 1'b0;
            r_chain      <= '0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                unique case (cfg_idx)
                    REG_KEY_HIGH: begin
                        r_key_high   <= pwdata;
                        r_keys_ready <= 1'b0;
                    end
                    REG_KEY_LOW: begin
                        r_key_low    <= pwdata;
                        r_keys_ready <= 1'b0;
                    end
                    REG_IV_HIGH:   r_iv_high   <= pwdata;
                    REG_IV_LOW:    r_iv_low    <= pwdata;
                    REG_CHAINING:  r_chaining  <= pwdata[0];
                    REG_DIRECTION: r_direction <= pwdata[0];
                    default: ;
                endcase
            end
            if (r_state == S_KEYX || r_state == S_ROUND) begin
                r_cnt <= RND_W'(r_cnt + 1'b1);
            end else begin
                r_cnt <= '0;
            end
            if (r_state == S_KEYX && r_cnt == RND_W'(ROUNDS - 1)) begin
                r_keys_ready <= 1'b1;
            end
            if (r_state == S_PREP) begin
                r_chain <= chain_cur;
            end
            if (r_state == S_FIN && out_free && r_chaining) begin
                r_chain <= r_direction ? r_blk : res;
            end
            if (r_state == S_FIN && out_free) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (blk_acc) begin
            r_blk   <= {i_blk.block_high, i_blk.block_low};
            r_first <= i_blk.first_block;
            r_w     <= {r_key_high[63:32] ^ FK[0], r_key_high[31:0] ^ FK[1],
                        r_key_low[63:32] ^ FK[2], r_key_low[31:0] ^ FK[3]};
        end else if (r_state == S_PREP) begin
            r_w <= blk_start;
        end else if (r_state == S_KEYX || r_state == S_ROUND) begin
            r_w <= {r_w[1], r_w[2], r_w[3], n_word};
        end
        if (r_state == S_FIN && out_free) begin
            r_out <= res;
        end
    end

    `SM4_ASSERT_NXT(a_acc_keyx, blk_acc && !r_keys_ready, r_state == S_KEYX,
        "block accepted without round keys did not start expansion")
    `SM4_ASSERT_NXT(a_keyx_done, r_state == S_KEYX && r_cnt == RND_W'(ROUNDS - 1),
        r_keys_ready && r_state == S_PREP, "key expansion end did not mark keys ready")
    `SM4_ASSERT_NXT(a_round_done, r_state == S_ROUND && r_cnt == RND_W'(ROUNDS - 1),
        r_state == S_FIN, "last round did not lead to result load")
    `SM4_ASSERT_NXT(a_fin_load, r_state == S_FIN && out_free, r_ov && r_state == S_IDLE,
        "result load did not fill the output register")
    `SM4_ASSERT_IMP(a_ready_idle, i_blk.ready, r_state != S_ROUND && r_state != S_KEYX,
        "ready raised while rounds in progress")

endmodule

// ===== hdl/sm4_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module sm4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== bench/sm4_block_cipher_ecb_cbc_core_tb.sv =====
`timescale 1ns / 100ps
// Testbench: SM4 ECB/CBC core checked beat by beat against a built-in cipher predictor
module sm4_block_cipher_ecb_cbc_core_tb import sm4_pkg::*;;

    localparam logic [63:0] MODE_ECB = 64'd0;
    localparam logic [63:0] MODE_CBC = 64'd1;
    localparam logic [63:0] DIR_ENC  = 64'd0;
    localparam logic [63:0] DIR_DEC  = 64'd1;
    localparam logic [63:0] ONES     = '1;

    localparam int RANDOM_ITEMS = 1300;
    localparam int CALM_PHASE   = 4;
    localparam int HOLD_PHASE   = 2;

    localparam logic [0:255][7:0] SBOX_T = {
        128'hd690e9fecce13db716b614c228fb2c05,
        128'h2b679a762abe04c3aa44132649860699,
        128'h9c4250f491ef987a33540b43edcfac62,
        128'he4b31ca9c908e89580df94fa758f3fa6,
        128'h4707a7fcf37317ba83593c19e6854fa8,
        128'h686b81b27164da8bf8eb0f4b70569d35,
        128'h1e240e5e6358d1a225227c3b01217887,
        128'hd40046579fd327524c3602e7a0c4c89e,
        128'heabf8ad240c738b5a3f7f2cef96115a1,
        128'he0ae5da49b341a55ad933230f58cb1e3,
        128'h1df6e22e8266ca60c02923ab0d534e6f,
        128'hd5db3745defd8e2f03ff6a726d6c5b51,
        128'h8d1baf92bbddbc7f11d95c411f105ad8,
        128'h0ac13188a5cd7bbd2d74d012b8e5b4b0,
        128'h8969974a0c96777e65b9f109c56ec684,
        128'h18f07dec3adc4d2079ee5f3ed7cb3948
    };

    localparam logic [31:0] SYS_PARAM [4] = '{
        32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc
    };

    typedef struct packed {
        logic [HALF_W-1:0] high;
        logic [HALF_W-1:0] low;
    } t_block;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    sm4_in_if  blk_if ();
    sm4_out_if res_if ();

    sm4_block_cipher_ecb_cbc_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_blk   (blk_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // cipher state as the block should hold it
    logic [63:0]  key_hi_q;
    logic [63:0]  key_lo_q;
    logic [127:0] iv_q;
    logic [127:0] chain_q;
    bit           cbc_q;
    bit           dec_q;
    logic [31:0]  rkey [ROUNDS];
    bit           rkey_valid;

    t_block result_blocks_due [$];
    int     mismatch_count = 0;
    int     idle_pct = 18;
    int     blocks_sent = 0;

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [31:0] subst(input logic [31:0] x);
        return {SBOX_T[x[31:24]], SBOX_T[x[23:16]], SBOX_T[x[15:8]], SBOX_T[x[7:0]]};
    endfunction

    function automatic logic [31:0] round_mix(input logic [31:0] x);
        logic [31:0] b;
        b = subst(x);
        return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
    endfunction

    function automatic logic [31:0] schedule_mix(input logic [31:0] x);
        logic [31:0] b;
        b = subst(x);
        return b ^ rotl(b, 13) ^ rotl(b, 23);
    endfunction

    function automatic logic [31:0] ck_const(input int i);
        logic [31:0] w;
        w = '0;
        for (int j = 0; j < 4; j++) begin
            w = {w[23:0], 8'((4 * i + j) * 7)};
        end
        return w;
    endfunction

    function automatic void expand_round_keys();
        logic [31:0] k [4];
        logic [31:0] nk;
        k[0] = key_hi_q[63:32] ^ SYS_PARAM[0];
        k[1] = key_hi_q[31:0]  ^ SYS_PARAM[1];
        k[2] = key_lo_q[63:32] ^ SYS_PARAM[2];
        k[3] = key_lo_q[31:0]  ^ SYS_PARAM[3];
        for (int i = 0; i < ROUNDS; i++) begin
            nk = k[0] ^ schedule_mix(k[1] ^ k[2] ^ k[3] ^ ck_const(i));
            k[0] = k[1];
            k[1] = k[2];
            k[2] = k[3];
            k[3] = nk;
            rkey[i] = nk;
        end
        rkey_valid = 1'b1;
    endfunction

    function automatic logic [127:0] sm4_cipher(input logic [127:0] blk, input bit dec);
        logic [31:0] x [4];
        logic [31:0] nx;
        logic [31:0] rk;
        for (int k = 0; k < 4; k++) begin
            x[k] = blk[127 - 32 * k -: 32];
        end
        for (int i = 0; i < ROUNDS; i++) begin
            rk = dec ? rkey[ROUNDS - 1 - i] : rkey[i];
            nx = x[0] ^ round_mix(x[1] ^ x[2] ^ x[3] ^ rk);
            x[0] = x[1];
            x[1] = x[2];
            x[2] = x[3];
            x[3] = nx;
        end
        return {x[3], x[2], x[1], x[0]};
    endfunction

    function automatic void reset_cipher_state();
        key_hi_q   = '0;
        key_lo_q   = '0;
        iv_q       = '0;
        chain_q    = '0;
        cbc_q      = 1'b0;
        dec_q      = 1'b0;
        rkey_valid = 1'b0;
    endfunction

    function automatic void compute_result_block(input logic [63:0] hi, input logic [63:0] lo,
                                                 input bit first);
        logic [127:0] din;
        logic [127:0] dout;
        din = {hi, lo};
        if (!rkey_valid) expand_round_keys();
        if (first) chain_q = iv_q;
        if (!cbc_q) begin
            dout = sm4_cipher(din, dec_q);
        end else if (!dec_q) begin
            dout = sm4_cipher(din ^ chain_q, 1'b0);
            chain_q = dout;
        end else begin
            dout = sm4_cipher(din, 1'b1) ^ chain_q;
            chain_q = din;
        end
        result_blocks_due.push_back(t_block'(dout));
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40) $display("ERROR %0t ns: %s", $time, msg);
    endtask

    task automatic apb_access(input bit wr, input int idx, input logic [63:0] wdata,
                              output logic [63:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= 6'(idx * 8);
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_reg(input int idx, input logic [63:0] value);
        logic [63:0] rd;
        logic [63:0] want;
        apb_access(1'b1, idx, value, rd);
        case (idx)
            REG_KEY_HIGH:  begin key_hi_q = value; rkey_valid = 1'b0; want = value; end
            REG_KEY_LOW:   begin key_lo_q = value; rkey_valid = 1'b0; want = value; end
            REG_IV_HIGH:   begin iv_q[127:64] = value; want = value; end
            REG_IV_LOW:    begin iv_q[63:0] = value; want = value; end
            REG_CHAINING:  begin cbc_q = value[0]; want = {63'd0, value[0]}; end
            REG_DIRECTION: begin dec_q = value[0]; want = {63'd0, value[0]}; end
            default:       return;
        endcase
        apb_access(1'b0, idx, '0, rd);
        if (rd !== want)
            report_mismatch($sformatf("register %0d reads %h, written %h", idx, rd, want));
    endtask

    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo, input bit first);
        int gap;
        gap = 0;
        if ($urandom_range(99) < idle_pct) gap = $urandom_range(1, 45);
        if (gap > 0) begin
            blk_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        blk_if.valid       <= 1'b1;
        blk_if.block_high  <= hi;
        blk_if.block_low   <= lo;
        blk_if.first_block <= first;
        do @(posedge i_clk); while (!blk_if.ready);
        compute_result_block(hi, lo, first);
        blocks_sent++;
    endtask

    // drop valid and hold until every due result has come back
    task automatic drain_results();
        blk_if.valid <= 1'b0;
        do @(posedge i_clk); while (result_blocks_due.size() != 0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic test_known_vector();
        write_reg(REG_KEY_HIGH, 64'h0123456789abcdef);
        write_reg(REG_KEY_LOW, 64'hfedcba9876543210);
        write_reg(REG_CHAINING, MODE_ECB);
        write_reg(REG_DIRECTION, DIR_ENC);
        send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0);
        if (result_blocks_due[$] !== {64'h681edf34d206965e, 64'h86b3e94f536e4246})
            report_mismatch("predictor disagrees with the standard SM4 vector");
        drain_results();
        write_reg(REG_DIRECTION, DIR_DEC);
        send_block(64'h681edf34d206965e, 64'h86b3e94f536e4246, 1'b0);
        drain_results();
    endtask

    task automatic test_field_extremes();
        write_reg(REG_KEY_HIGH, '0);
        write_reg(REG_KEY_LOW, '0);
        write_reg(REG_DIRECTION, DIR_ENC);
        send_block('0, '0, 1'b0);
        send_block(ONES, ONES, 1'b1);
        send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0);
        drain_results();
        write_reg(REG_DIRECTION, DIR_DEC);
        send_block(ONES, '0, 1'b1);
        send_block('0, ONES, 1'b0);
        drain_results();
        write_reg(REG_KEY_HIGH, ONES);
        write_reg(REG_KEY_LOW, ONES);
        write_reg(REG_DIRECTION, DIR_ENC);
        send_block('0, ONES, 1'b1);
        drain_results();
        write_reg(REG_DIRECTION, DIR_DEC);
        send_block(ONES, ONES, 1'b0);
        drain_results();
    endtask

    task automatic test_cbc_chains();
        t_block ct [3];
        write_reg(REG_KEY_HIGH, rand64());
        write_reg(REG_KEY_LOW, rand64());
        write_reg(REG_IV_HIGH, rand64());
        write_reg(REG_IV_LOW, rand64());
        write_reg(REG_CHAINING, MODE_CBC);
        write_reg(REG_DIRECTION, DIR_ENC);
        for (int i = 0; i < 3; i++) begin
            send_block(rand64(), rand64(), i == 0);
            ct[i] = result_blocks_due[$];
        end
        drain_results();
        // decrypt the chain just produced
        write_reg(REG_DIRECTION, DIR_DEC);
        for (int i = 0; i < 3; i++) send_block(ct[i].high, ct[i].low, i == 0);
        drain_results();
        // chain loads from the IV on a first block even in ECB
        write_reg(REG_CHAINING, MODE_ECB);
        write_reg(REG_DIRECTION, DIR_ENC);
        write_reg(REG_IV_HIGH, rand64());
        write_reg(REG_IV_LOW, rand64());
        send_block(rand64(), rand64(), 1'b1);
        drain_results();
        write_reg(REG_CHAINING, MODE_CBC);
        send_block(rand64(), rand64(), 1'b0);
        drain_results();
        write_reg(REG_DIRECTION, DIR_DEC);
        send_block(rand64(), rand64(), 1'b0);
        drain_results();
    endtask

    task automatic test_key_change();
        write_reg(REG_DIRECTION, DIR_ENC);
        write_reg(REG_KEY_HIGH, rand64());
        send_block(rand64(), rand64(), 1'b0);
        drain_results();
        write_reg(REG_KEY_LOW, rand64());
        send_block(rand64(), rand64(), 1'b0);
        drain_results();
    endtask

    task automatic test_bad_index();
        write_reg(REG_COUNT, rand64());
        write_reg(REG_COUNT + 1, rand64());
        send_block(rand64(), rand64(), 1'b0);
        drain_results();
    endtask

    task automatic test_random_chains();
        int target;
        int phase;
        int n_chains;
        int len;
        int kind;
        bit first;
        target = blocks_sent + RANDOM_ITEMS;
        phase  = 0;
        while (blocks_sent < target) begin
            if (phase == 0 || $urandom_range(3) == 0) begin
                kind = $urandom_range(9);
                write_reg(REG_KEY_HIGH, kind == 0 ? '0 : kind == 1 ? ONES : rand64());
                if ($urandom_range(4) != 0)
                    write_reg(REG_KEY_LOW, kind == 0 ? '0 : kind == 1 ? ONES : rand64());
            end
            if ($urandom_range(1)) begin
                write_reg(REG_IV_HIGH, rand64());
                write_reg(REG_IV_LOW, rand64());
            end
            write_reg(REG_CHAINING, rand64());
            write_reg(REG_DIRECTION, rand64());
            idle_pct = (phase == CALM_PHASE) ? 0 : 18;
            n_chains = $urandom_range(1, 4);
            for (int c = 0; c < n_chains; c++) begin
                len = (phase == CALM_PHASE) ? 40 : $urandom_range(1, 12);
                for (int b = 0; b < len; b++) begin
                    first = (b == 0);
                    if ($urandom_range(9) == 0) first = $urandom_range(1);
                    send_block(rand64(), rand64(), first);
                    if (phase == HOLD_PHASE && b == len / 2) drain_results();
                end
            end
            drain_results();
            phase++;
        end
        idle_pct = 18;
    endtask

    always @(posedge i_clk) begin
        t_block due;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (result_blocks_due.size() == 0) begin
                report_mismatch($sformatf("result beat %h_%h with none due",
                                          res_if.result_high, res_if.result_low));
            end else begin
                due = result_blocks_due.pop_front();
                if (res_if.result_high !== due.high)
                    report_mismatch($sformatf("result_high %h, due %h",
                                              res_if.result_high, due.high));
                if (res_if.result_low !== due.low)
                    report_mismatch($sformatf("result_low %h, due %h",
                                              res_if.result_low, due.low));
            end
        end
    end

    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            res_if.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    initial begin
        #(20_000_000);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        i_rst_n            <= 1'b0;
        blk_if.valid       <= 1'b0;
        blk_if.block_high  <= '0;
        blk_if.block_low   <= '0;
        blk_if.first_block <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        reset_cipher_state();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_known_vector();
        test_field_extremes();
        test_cbc_chains();
        test_key_change();
        test_bad_index();
        test_random_chains();

        drain_results();
        repeat (70) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
